// File: sv/ccr_pkg.sv
`default_nettype none

package ccr_pkg;

  // Default number of fraction bits of positions, velocities and masses.
  localparam int FRAC_BITS_DEF = 16;

  // Depth of the queue between the classifier and the solver.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int LVL_W   = 3;
  localparam logic [LVL_W-1:0] Q_FULL = LVL_W'(Q_DEPTH);

  // Restitution of one in Q1.16.
  localparam logic [17:0] BOUNCE_ONE = 18'd65536;

  // One pair of circles as it arrives.
  typedef struct packed {
    logic [63:0] pos_a;
    logic [63:0] vel_a;
    logic [23:0] radius_a;
    logic [23:0] inv_mass_a;
    logic [16:0] bounce_a;
    logic [63:0] pos_b;
    logic [63:0] vel_b;
    logic [23:0] radius_b;
    logic [23:0] inv_mass_b;
    logic [16:0] bounce_b;
  } ccr_in_t;

  // One resolved pair.
  typedef struct packed {
    logic [63:0] new_pos_a;
    logic [63:0] new_vel_a;
    logic [63:0] new_pos_b;
    logic [63:0] new_vel_b;
    logic        collided;
  } ccr_out_t;

  // A classified pair as it sits in the queue.
  typedef struct packed {
    ccr_in_t            item;
    logic               collided;
    logic               zero_sum;
    logic signed [25:0] dx;
    logic signed [25:0] dy;
    logic signed [32:0] rvx;
    logic signed [32:0] rvy;
    logic [24:0]        rsum;
    logic [50:0]        d2;
    logic [24:0]        sum;
    logic [17:0]        gain;
  } ccr_cls_t;

  // Everything one solver stage carries.
  typedef struct packed {
    ccr_cls_t           c;
    logic [27:0]        srem;
    logic [25:0]        root;
    logic [24:0]        pen;
    logic [48:0]        pa;
    logic [48:0]        pb;
    logic [25:0]        nrx;
    logic [25:0]        nry;
    logic [24:0]        nqx;
    logic [24:0]        nqy;
    logic [24:0]        kra;
    logic [24:0]        krb;
    logic [24:0]        ka;
    logic [24:0]        kb;
    logic signed [25:0] nx;
    logic signed [25:0] ny;
    logic signed [51:0] kxa;
    logic signed [51:0] kya;
    logic signed [51:0] kxb;
    logic signed [51:0] kyb;
    logic signed [58:0] vpx;
    logic signed [58:0] vpy;
    logic [63:0]        npa;
    logic [63:0]        npb;
    logic signed [34:0] vn;
    logic [51:0]        qp;
    logic [58:0]        jpa;
    logic [58:0]        jpb;
    logic [24:0]        jra;
    logic [24:0]        jrb;
    logic [34:0]        ja;
    logic [34:0]        jb;
    logic signed [61:0] jxa;
    logic signed [61:0] jya;
    logic signed [61:0] jxb;
    logic signed [61:0] jyb;
    ccr_out_t           res;
  } ccr_work_t;

  // Queue status seen by the classifier and the solver.
  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             avail;
  } ccr_qstat_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -38'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/ccr_front.sv
`default_nettype none

module ccr_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pair_valid,
  output logic                 pair_stall,
  input  ccr_pkg::ccr_in_t     pair,
  input  ccr_pkg::ccr_qstat_t  qstat,
  output logic                 push,
  output ccr_pkg::ccr_cls_t    cls
);

  typedef struct packed {
    ccr_pkg::ccr_in_t   item;
    logic signed [34:0] dx;
    logic signed [34:0] dy;
    logic signed [32:0] rvx;
    logic signed [32:0] rvy;
    logic [24:0]        rsum;
    logic [24:0]        sum;
    logic [17:0]        gain;
  } f1_t;

  typedef struct packed {
    ccr_pkg::ccr_in_t   item;
    logic               box_far;
    logic signed [25:0] dx;
    logic signed [25:0] dy;
    logic [50:0]        sqx;
    logic [50:0]        sqy;
    logic [49:0]        rsq;
    logic signed [32:0] rvx;
    logic signed [32:0] rvy;
    logic [24:0]        rsum;
    logic [24:0]        sum;
    logic [17:0]        gain;
  } f2_t;

  logic             v1;
  logic             v2;
  f1_t              r1;
  f1_t              r1_next;
  f2_t              r2;
  f2_t              r2_next;
  logic             accept;
  logic [ccr_pkg::LVL_W-1:0] booked;

  // Space is booked for every pair still in the two classifier stages.
  assign booked     = qstat.level + {{(ccr_pkg::LVL_W-1){1'b0}}, v1}
                                  + {{(ccr_pkg::LVL_W-1){1'b0}}, v2};
  assign pair_stall = (booked >= ccr_pkg::Q_FULL);
  assign accept     = pair_valid && !pair_stall;

  // First stage: center differences, relative velocity, sums and restitution.
  always_comb begin
    logic signed [31:0] xa, ya, xb, yb, vxa, vya, vxb, vyb;
    logic signed [34:0] ra, rb;
    logic [16:0]        e;
    xa  = $signed(pair.pos_a[63:32]);
    ya  = $signed(pair.pos_a[31:0]);
    xb  = $signed(pair.pos_b[63:32]);
    yb  = $signed(pair.pos_b[31:0]);
    vxa = $signed(pair.vel_a[63:32]);
    vya = $signed(pair.vel_a[31:0]);
    vxb = $signed(pair.vel_b[63:32]);
    vyb = $signed(pair.vel_b[31:0]);
    ra  = $signed({11'b0, pair.radius_a});
    rb  = $signed({11'b0, pair.radius_b});
    r1_next.item = pair;
    r1_next.dx   = 35'(xb) + rb - 35'(xa) - ra;
    r1_next.dy   = 35'(yb) + rb - 35'(ya) - ra;
    r1_next.rvx  = 33'(vxb) - 33'(vxa);
    r1_next.rvy  = 33'(vyb) - 33'(vya);
    r1_next.rsum = {1'b0, pair.radius_a} + {1'b0, pair.radius_b};
    r1_next.sum  = {1'b0, pair.inv_mass_a} + {1'b0, pair.inv_mass_b};
    e = (pair.bounce_a < pair.bounce_b) ? pair.bounce_a : pair.bounce_b;
    if ({1'b0, e} > ccr_pkg::BOUNCE_ONE) begin
      r1_next.gain = ccr_pkg::BOUNCE_ONE + ccr_pkg::BOUNCE_ONE;
    end else begin
      r1_next.gain = {1'b0, e} + ccr_pkg::BOUNCE_ONE;
    end
  end

  // Second stage: bounding box test and the squares.
  always_comb begin
    logic signed [34:0] adx, ady, rs;
    logic signed [51:0] sx, sy;
    adx = r1.dx[34] ? -r1.dx : r1.dx;
    ady = r1.dy[34] ? -r1.dy : r1.dy;
    rs  = $signed({10'b0, r1.rsum});
    sx  = $signed(r1.dx[25:0]) * $signed(r1.dx[25:0]);
    sy  = $signed(r1.dy[25:0]) * $signed(r1.dy[25:0]);
    r2_next.item    = r1.item;
    r2_next.box_far = (adx > rs) || (ady > rs);
    r2_next.dx      = r1.dx[25:0];
    r2_next.dy      = r1.dy[25:0];
    r2_next.sqx     = sx[50:0];
    r2_next.sqy     = sy[50:0];
    r2_next.rsq     = r1.rsum * r1.rsum;
    r2_next.rvx     = r1.rvx;
    r2_next.rvy     = r1.rvy;
    r2_next.rsum    = r1.rsum;
    r2_next.sum     = r1.sum;
    r2_next.gain    = r1.gain;
  end

  // Stage registers; the stages never hold since queue space is booked.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    r1 <= r1_next;
    r2 <= r2_next;
  end

  // Final classification on the way into the queue.
  always_comb begin
    logic [50:0] d2;
    d2 = r2.sqx + r2.sqy;
    cls.item     = r2.item;
    cls.collided = !(r2.box_far || (d2 > {1'b0, r2.rsq}));
    cls.zero_sum = (r2.sum == '0);
    cls.dx       = r2.dx;
    cls.dy       = r2.dy;
    cls.rvx      = r2.rvx;
    cls.rvy      = r2.rvy;
    cls.rsum     = r2.rsum;
    cls.d2       = d2;
    cls.sum      = r2.sum;
    cls.gain     = r2.gain;
  end

  assign push = v2;

endmodule

`default_nettype wire

// File: sv/ccr_queue.sv
`default_nettype none

module ccr_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ccr_pkg::ccr_cls_t    wdata,
  input  logic                 pop,
  output ccr_pkg::ccr_cls_t    head,
  output ccr_pkg::ccr_qstat_t  qstat
);

  ccr_pkg::ccr_cls_t              slots [ccr_pkg::Q_DEPTH];
  logic [ccr_pkg::Q_PTR_W-1:0]    wptr;
  logic [ccr_pkg::Q_PTR_W-1:0]    rptr;
  logic [ccr_pkg::LVL_W-1:0]      level;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  assign head        = slots[rptr];
  assign qstat.level = level;
  assign qstat.avail = (level != '0);

  // The classifier books space, so the queue never overflows.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (level != ccr_pkg::Q_FULL))
    else $error("Queue written while full.");

  // The solver only takes an entry that is there.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (level != '0))
    else $error("Queue read while empty.");

  // A transfer in without one out leaves the queue non-empty.
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (level != '0))
    else $error("Queue level lost an entry.");

endmodule

`default_nettype wire

// File: sv/ccr_back.sv
`default_nettype none

module ccr_back #(
  parameter int FRAC_BITS = ccr_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ccr_pkg::ccr_cls_t    head,
  input  ccr_pkg::ccr_qstat_t  qstat,
  output logic                 pop,
  output logic                 res_valid,
  input  logic                 res_stall,
  output ccr_pkg::ccr_out_t    res
);

  // Stage map of the solver pipeline.
  localparam int SQ_N     = 26;
  localparam int K_N      = 25;
  localparam int J_N      = 35;
  localparam int NQ       = FRAC_BITS + 1;
  localparam int MIN_DIST = ((1 << FRAC_BITS) + 5000) / 10000;
  localparam int S_PEN    = SQ_N;
  localparam int S_KD     = S_PEN + 1;
  localparam int S_NSEL   = S_KD + K_N;
  localparam int S_M1     = S_NSEL + 1;
  localparam int S_M2     = S_M1 + 1;
  localparam int S_M3     = S_M2 + 1;
  localparam int S_M4     = S_M3 + 1;
  localparam int S_JD     = S_M4 + 1;
  localparam int S_M6     = S_JD + J_N;
  localparam int S_M7     = S_M6 + 1;
  localparam int N_STG    = S_M7 + 1;

  localparam logic [25:0] MIN_D  = 26'(MIN_DIST);
  localparam logic signed [25:0] ONE_N = 26'(1) << FRAC_BITS;

  ccr_pkg::ccr_work_t stg [N_STG+1];
  logic               vld [N_STG+1];
  logic               adv;

  // Divide by 2^FRAC_BITS, truncating toward zero.
  function automatic logic signed [61:0] tz(input logic signed [61:0] p);
    logic signed [61:0] bias;
    bias = p[61] ? ((62'sd1 <<< FRAC_BITS) - 62'sd1) : 62'sd0;
    return (p + bias) >>> FRAC_BITS;
  endfunction

  // Work done between stage k and stage k + 1.
  function automatic ccr_pkg::ccr_work_t stage_fn(input int k,
                                                  input ccr_pkg::ccr_work_t w);
    ccr_pkg::ccr_work_t r;
    int                 i;
    logic [51:0]        d2p;
    logic [29:0]        spre;
    logic [29:0]        strial;
    logic [25:0]        adx, ady;
    logic [25:0]        nrx_in, nry_in;
    logic               bx, by;
    logic [26:0]        npx, npy;
    logic [24:0]        ra_in, rb_in;
    logic [25:0]        pra, prb;
    logic signed [31:0] xa, ya, xb, yb, vxa, vya, vxb, vyb;
    logic [34:0]        nv;
    logic [63:0]        nva, nvb;
    r   = w;
    i   = 0;
    d2p = {1'b0, w.c.d2};
    adx = w.c.dx[25] ? 26'(-w.c.dx) : w.c.dx;
    ady = w.c.dy[25] ? 26'(-w.c.dy) : w.c.dy;
    xa  = $signed(w.c.item.pos_a[63:32]);
    ya  = $signed(w.c.item.pos_a[31:0]);
    xb  = $signed(w.c.item.pos_b[63:32]);
    yb  = $signed(w.c.item.pos_b[31:0]);
    vxa = $signed(w.c.item.vel_a[63:32]);
    vya = $signed(w.c.item.vel_a[31:0]);
    vxb = $signed(w.c.item.vel_b[63:32]);
    vyb = $signed(w.c.item.vel_b[31:0]);
    if (k < S_PEN) begin
      // One result bit of the integer square root.
      i      = k;
      spre   = {w.srem, d2p[51-2*i -: 2]};
      strial = {2'b00, w.root, 2'b01};
      if (spre >= strial) begin
        r.srem = 28'(spre - strial);
        r.root = {w.root[24:0], 1'b1};
      end else begin
        r.srem = spre[27:0];
        r.root = {w.root[24:0], 1'b0};
      end
    end else if (k == S_PEN) begin
      // Penetration depth and its products with the inverse masses.
      r.pen = w.c.rsum - w.root[24:0];
      r.pa  = r.pen * w.c.item.inv_mass_a;
      r.pb  = r.pen * w.c.item.inv_mass_b;
    end else if (k < S_NSEL) begin
      // One quotient bit of the mass split and, early on, of the normal.
      i     = k - S_KD;
      ra_in = (i == 0) ? {1'b0, w.pa[48:25]} : w.kra;
      rb_in = (i == 0) ? {1'b0, w.pb[48:25]} : w.krb;
      pra   = {ra_in, w.pa[24-i]};
      prb   = {rb_in, w.pb[24-i]};
      if (pra >= {1'b0, w.c.sum}) begin
        r.kra = 25'(pra - {1'b0, w.c.sum});
        r.ka  = {w.ka[23:0], 1'b1};
      end else begin
        r.kra = pra[24:0];
        r.ka  = {w.ka[23:0], 1'b0};
      end
      if (prb >= {1'b0, w.c.sum}) begin
        r.krb = 25'(prb - {1'b0, w.c.sum});
        r.kb  = {w.kb[23:0], 1'b1};
      end else begin
        r.krb = prb[24:0];
        r.kb  = {w.kb[23:0], 1'b0};
      end
      if (i < NQ) begin
        nrx_in = (i == 0) ? {1'b0, adx[25:1]} : w.nrx;
        nry_in = (i == 0) ? {1'b0, ady[25:1]} : w.nry;
        bx     = (i == 0) ? adx[0] : 1'b0;
        by     = (i == 0) ? ady[0] : 1'b0;
        npx    = {nrx_in, bx};
        npy    = {nry_in, by};
        if (npx >= {1'b0, w.root}) begin
          r.nrx = 26'(npx - {1'b0, w.root});
          r.nqx = {w.nqx[23:0], 1'b1};
        end else begin
          r.nrx = npx[25:0];
          r.nqx = {w.nqx[23:0], 1'b0};
        end
        if (npy >= {1'b0, w.root}) begin
          r.nry = 26'(npy - {1'b0, w.root});
          r.nqy = {w.nqy[23:0], 1'b1};
        end else begin
          r.nry = npy[25:0];
          r.nqy = {w.nqy[23:0], 1'b0};
        end
      end
    end else if (k == S_NSEL) begin
      // Contact normal; coincident centers fall back to the x axis.
      if (w.root > MIN_D) begin
        r.nx = w.c.dx[25] ? -$signed({1'b0, w.nqx}) : $signed({1'b0, w.nqx});
        r.ny = w.c.dy[25] ? -$signed({1'b0, w.nqy}) : $signed({1'b0, w.nqy});
      end else begin
        r.nx = ONE_N;
        r.ny = '0;
      end
    end else if (k == S_M1) begin
      // Position shift products and the normal velocity products.
      r.kxa = $signed({1'b0, w.ka}) * w.nx;
      r.kya = $signed({1'b0, w.ka}) * w.ny;
      r.kxb = $signed({1'b0, w.kb}) * w.nx;
      r.kyb = $signed({1'b0, w.kb}) * w.ny;
      r.vpx = w.c.rvx * w.nx;
      r.vpy = w.c.rvy * w.ny;
    end else if (k == S_M2) begin
      // Corrected corners and the normal velocity.
      r.npa = {ccr_pkg::sat32(38'(xa) - 38'(tz(62'(w.kxa)))),
               ccr_pkg::sat32(38'(ya) - 38'(tz(62'(w.kya))))};
      r.npb = {ccr_pkg::sat32(38'(xb) + 38'(tz(62'(w.kxb)))),
               ccr_pkg::sat32(38'(yb) + 38'(tz(62'(w.kyb))))};
      r.vn  = 35'(tz(62'(w.vpx) + 62'(w.vpy)));
    end else if (k == S_M3) begin
      // Impulse magnitude before the restitution scale is dropped.
      nv   = 35'(-w.vn);
      r.qp = w.c.gain * nv;
    end else if (k == S_M4) begin
      // Impulse times inverse mass.
      r.jpa = w.qp[50:16] * w.c.item.inv_mass_a;
      r.jpb = w.qp[50:16] * w.c.item.inv_mass_b;
    end else if (k < S_M6) begin
      // One quotient bit of the impulse split.
      i     = k - S_JD;
      ra_in = (i == 0) ? {1'b0, w.jpa[58:35]} : w.jra;
      rb_in = (i == 0) ? {1'b0, w.jpb[58:35]} : w.jrb;
      pra   = {ra_in, w.jpa[34-i]};
      prb   = {rb_in, w.jpb[34-i]};
      if (pra >= {1'b0, w.c.sum}) begin
        r.jra = 25'(pra - {1'b0, w.c.sum});
        r.ja  = {w.ja[33:0], 1'b1};
      end else begin
        r.jra = pra[24:0];
        r.ja  = {w.ja[33:0], 1'b0};
      end
      if (prb >= {1'b0, w.c.sum}) begin
        r.jrb = 25'(prb - {1'b0, w.c.sum});
        r.jb  = {w.jb[33:0], 1'b1};
      end else begin
        r.jrb = prb[24:0];
        r.jb  = {w.jb[33:0], 1'b0};
      end
    end else if (k == S_M6) begin
      // Velocity change products.
      r.jxa = $signed({1'b0, w.ja}) * w.nx;
      r.jya = $signed({1'b0, w.ja}) * w.ny;
      r.jxb = $signed({1'b0, w.jb}) * w.nx;
      r.jyb = $signed({1'b0, w.jb}) * w.ny;
    end else begin
      // Result selection.
      nva = {ccr_pkg::sat32(38'(vxa) - 38'(tz(w.jxa))),
             ccr_pkg::sat32(38'(vya) - 38'(tz(w.jya)))};
      nvb = {ccr_pkg::sat32(38'(vxb) + 38'(tz(w.jxb))),
             ccr_pkg::sat32(38'(vyb) + 38'(tz(w.jyb)))};
      r.res.new_pos_a = w.c.item.pos_a;
      r.res.new_vel_a = w.c.item.vel_a;
      r.res.new_pos_b = w.c.item.pos_b;
      r.res.new_vel_b = w.c.item.vel_b;
      r.res.collided  = w.c.collided;
      if (w.c.collided && !w.c.zero_sum) begin
        r.res.new_pos_a = w.npa;
        r.res.new_pos_b = w.npb;
        if (w.vn < 0) begin
          r.res.new_vel_a = nva;
          r.res.new_vel_b = nvb;
        end
      end
    end
    return r;
  endfunction

  // The whole pipeline moves unless a finished result is held.
  assign adv = !vld[N_STG] || !res_stall;
  assign pop = adv && qstat.avail;

  always_comb begin
    stg[0]   = '0;
    stg[0].c = head;
    vld[0]   = qstat.avail;
  end

  for (genvar k = 0; k < N_STG; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg[k+1] <= stage_fn(k, stg[k]);
      end
    end
  end

  assign res_valid = vld[N_STG];
  assign res       = stg[N_STG].res;

endmodule

`default_nettype wire

// File: sv/circle_collision_resolver.sv
`default_nettype none

// Resolves one pair of circles per transfer and takes a new pair every cycle
// while pair_stall is low. A pair passes two classifier stages, the queue,
// and a 94-stage solver made of a 26-step square root pipeline, a 25-step
// divider for the mass split, a 35-step divider for the impulse split and a
// few multiply stages. Results come out in input order. The solver holds as a
// whole while res_stall is high and a result waits; pair_stall rises once the
// four-entry queue's level plus the pairs in the classifier reaches its depth.
module circle_collision_resolver #(
  parameter int FRAC_BITS = ccr_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pair_valid,
  output logic               pair_stall,
  input  ccr_pkg::ccr_in_t   pair,
  output logic               res_valid,
  input  logic               res_stall,
  output ccr_pkg::ccr_out_t  res
);

  logic                 push;
  logic                 pop;
  ccr_pkg::ccr_cls_t    cls;
  ccr_pkg::ccr_cls_t    head;
  ccr_pkg::ccr_qstat_t  qstat;

  // Classifier: differences, overlap test and pair constants.
  ccr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pair_valid),
    .pair_stall (pair_stall),
    .pair       (pair),
    .qstat      (qstat),
    .push       (push),
    .cls        (cls)
  );

  // Queue between classifier and solver.
  ccr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // Solver: distance, normal, correction and impulse.
  ccr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire
